/* rtl/glyph_quad_emitter_macros.svh */
// assertion helpers
`ifndef GLYPH_QUAD_EMITTER_MACROS_SVH
`define GLYPH_QUAD_EMITTER_MACROS_SVH
`define GQE_ASSERT_IMP(label, a, c) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (c)) \
        else $error("assertion failed");
`define GQE_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

/* rtl/gqe_pkg.sv */
package gqe_pkg;
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_DRAW  = 2'd2;

    localparam logic [2:0] REG_FONT_SIZE   = 3'd0;
    localparam logic [2:0] REG_SPACING     = 3'd1;
    localparam logic [2:0] REG_COLOR       = 3'd2;
    localparam logic [2:0] REG_S_SCALE     = 3'd3;
    localparam logic [2:0] REG_T_SCALE     = 3'd4;
    localparam logic [2:0] REG_GLYPH_COUNT = 3'd5;

    localparam logic [1:0] CORNER_TL = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_FETCH, ST_STEP, ST_CALC, ST_OUT
    } state_t;

    typedef struct packed {
        logic read_en;     // memory read at scan index, or found index with fetch_sel
        logic scan_clear;  // reset scan index
        logic scan_inc;
        logic fetch_sel;   // read at found index
        logic latch_entry; // capture read data as glyph
        logic step_mul;    // compute step product
        logic commit;      // update pen, width, counter
        logic start;       // start item
        logic calc;        // compute current corner
        logic corner_inc;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic hit;
        logic last_corner;
    } status_t;
endpackage

/* rtl/gqe_ctrl.sv */
module gqe_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [1:0]       op,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  gqe_pkg::status_t status,
    output gqe_pkg::cmd_t    cmd
);
    import gqe_pkg::*;

    state_t state_reg, state_next;
    logic   acc;

    assign acc = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (acc && op == OP_DRAW) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (status.hit || status.scan_done) state_next = ST_FETCH;
            end
            ST_FETCH: state_next = ST_STEP;
            ST_STEP:  state_next = ST_CALC;
            ST_CALC:  state_next = ST_OUT;
            ST_OUT: begin
                if (m_tready) state_next = status.last_corner ? ST_IDLE : ST_CALC;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.scan_clear = 1'b1;
                cmd.start = acc && op == OP_START;
            end
            ST_SCAN: begin
                cmd.read_en = 1'b1;
                cmd.scan_inc = !(status.hit || status.scan_done);
            end
            ST_FETCH: begin
                cmd.read_en = 1'b1;
                cmd.fetch_sel = 1'b1;
            end
            ST_STEP: begin
                cmd.latch_entry = 1'b1;
                cmd.step_mul = 1'b1;
            end
            ST_CALC: cmd.calc = 1'b1;
            ST_OUT: begin
                m_tvalid = 1'b1;
                cmd.corner_inc = m_tready;
                cmd.commit = m_tready && status.last_corner;
            end
            default: ;
        endcase
    end
endmodule

/* rtl/gqe_datapath.sv */
module gqe_datapath #(
    parameter int GLYPH_ENTRIES   = 256,
    parameter int QUADS_PER_BATCH = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  gqe_pkg::cmd_t    cmd,
    output gqe_pkg::status_t status,
    input  logic             load_en,
    input  logic [7:0]       entry_index,
    input  logic [7:0]       codepoint,
    input  logic [15:0]      advance,
    input  logic [63:0]      plane_box,
    input  logic [63:0]      atlas_box,
    input  logic [31:0]      pen_x,
    input  logic [31:0]      pen_y,
    input  logic [15:0]      font_size,
    input  logic [15:0]      glyph_spacing,
    input  logic [31:0]      text_color,
    input  logic [31:0]      tex_s_scale,
    input  logic [31:0]      tex_t_scale,
    input  logic [8:0]       glyph_count,
    output logic [1:0]       corner,
    output logic [31:0]      vertex_x,
    output logic [31:0]      vertex_y,
    output logic [15:0]      tex_s,
    output logic [15:0]      tex_t,
    output logic [31:0]      vertex_color,
    output logic [9:0]       quad_slot,
    output logic             batch_full,
    output logic [31:0]      line_width,
    output logic             last
);
    import gqe_pkg::*;

    localparam int AW = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
    localparam int IW = $clog2(GLYPH_ENTRIES + 1);
    localparam int CW = (QUADS_PER_BATCH > 1) ? $clog2(QUADS_PER_BATCH) : 1;
    localparam int LW = (IW > 9) ? IW : 9;

    logic [7:0]   code_mem  [GLYPH_ENTRIES];
    logic [143:0] entry_mem [GLYPH_ENTRIES];

    logic [IW-1:0]  scan_reg;
    logic [AW-1:0]  found_reg;
    logic [7:0]     want_reg;
    logic [7:0]     code_rd_reg;
    logic [143:0]   entry_rd_reg;
    logic           rd_valid_reg;
    logic [IW-1:0]  rd_idx_reg;
    logic [63:0]    plane_reg, atlas_reg;
    logic signed [31:0] pen_x_reg, pen_y_reg, width_reg, step_reg;
    logic [CW-1:0]  quad_reg;
    logic [1:0]     corner_reg;

    logic [LW-1:0] limit;
    logic [AW-1:0] rd_addr;
    logic hit, done;

    always_comb begin
        limit = (LW'(glyph_count) < LW'(GLYPH_ENTRIES)) ? LW'(glyph_count)
                                                          : LW'(GLYPH_ENTRIES);
    end

    assign rd_addr = cmd.fetch_sel ? found_reg : scan_reg[AW-1:0];
    assign hit  = rd_valid_reg && (code_rd_reg == want_reg);
    assign done = LW'(scan_reg) >= limit;

    // scan reads one entry per cycle; the compare uses the registered read in the next cycle
    always_ff @(posedge aclk) begin
        if (load_en && 32'(entry_index) < GLYPH_ENTRIES) begin
            code_mem[AW'(entry_index)]  <= codepoint;
            entry_mem[AW'(entry_index)] <= {advance, plane_box, atlas_box};
        end
        if (cmd.read_en) begin
            code_rd_reg  <= code_mem[rd_addr];
            entry_rd_reg <= entry_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg     <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= '0;
            want_reg     <= '0;
        end else if (cmd.scan_clear) begin
            scan_reg     <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= '0;
            want_reg     <= codepoint;
        end else if (cmd.read_en && !cmd.fetch_sel) begin
            if (hit) begin
                found_reg <= rd_idx_reg[AW-1:0];
            end
            rd_valid_reg <= cmd.scan_inc && !done;
            rd_idx_reg   <= scan_reg;
            if (cmd.scan_inc && !done) scan_reg <= scan_reg + 1'b1;
        end
    end

    assign status.hit         = hit;
    assign status.scan_done   = done && !rd_valid_reg;
    assign status.last_corner = corner_reg == CORNER_TL;

    function automatic logic signed [31:0] sat(input logic signed [33:0] v);
        if (v > 34'sh07FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -34'sh080000000) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [33:0] rnd(input logic signed [47:0] p);
        logic signed [47:0] t;
        t = p + 48'sd8192;
        return t[47:14];
    endfunction

    logic signed [47:0] step_prod;
    logic signed [33:0] step_sum;
    assign step_prod = $signed(entry_rd_reg[143:128]) * $signed({1'b0, font_size});
    assign step_sum  = rnd(step_prod) + 34'($signed(glyph_spacing));

    always_ff @(posedge aclk) begin
        if (cmd.latch_entry) begin
            plane_reg <= entry_rd_reg[127:64];
            atlas_reg <= entry_rd_reg[63:0];
            step_reg  <= sat(step_sum);
        end
    end

    logic [1:0] hs, vs;
    logic signed [15:0] ph, pv;
    logic [15:0] ah, av;
    logic signed [47:0] xp, yp;
    logic [47:0] sp, tp;
    logic [32:0] sr, tr;

    assign hs = (corner_reg == 2'd1 || corner_reg == 2'd2) ? 2'd2 : 2'd0;
    assign vs = corner_reg[1] ? 2'd3 : 2'd1;
    assign ph = plane_reg[16*hs +: 16];
    assign pv = plane_reg[16*vs +: 16];
    assign ah = atlas_reg[16*hs +: 16];
    assign av = atlas_reg[16*vs +: 16];
    assign xp = 48'(ph) * $signed({1'b0, font_size});
    assign yp = (48'sd16384 - 48'(pv)) * $signed({1'b0, font_size});
    assign sp = 48'(ah) * 48'(tex_s_scale);
    assign tp = 48'(av) * 48'(tex_t_scale);
    assign sr = 33'((sp + 48'd32768) >> 16);
    assign tr = 33'((49'h100000000 - 49'(tp) + 49'd32768) >> 16);

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            corner       <= corner_reg;
            vertex_x     <= sat(34'(pen_x_reg) + rnd(xp));
            vertex_y     <= sat(34'(pen_y_reg) + rnd(yp));
            tex_s        <= (sr > 33'd65535) ? 16'hFFFF : sr[15:0];
            tex_t        <= (tp >= 48'h100000000) ? 16'd0 :
                            ((tr > 33'd65535) ? 16'hFFFF : tr[15:0]);
            vertex_color <= text_color;
            quad_slot    <= 10'(quad_reg);
            batch_full   <= 32'(quad_reg) + 1 >= QUADS_PER_BATCH;
            line_width   <= sat(34'(width_reg) + 34'(step_reg));
            last         <= corner_reg == CORNER_TL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_x_reg  <= '0;
            pen_y_reg  <= '0;
            width_reg  <= '0;
            quad_reg   <= '0;
            corner_reg <= '0;
        end else begin
            if (cmd.start) begin
                pen_x_reg <= pen_x;
                pen_y_reg <= pen_y;
                width_reg <= '0;
                quad_reg  <= '0;
            end
            if (cmd.corner_inc) corner_reg <= corner_reg + 1'b1;
            if (cmd.commit) begin
                pen_x_reg <= sat(34'(pen_x_reg) + 34'(step_reg));
                width_reg <= sat(34'(width_reg) + 34'(step_reg));
                quad_reg  <= (32'(quad_reg) + 1 >= QUADS_PER_BATCH) ? '0
                                                                   : quad_reg + 1'b1;
            end
        end
    end
endmodule

/* rtl/glyph_quad_emitter.sv */
// Load and start words are taken whenever the block is idle. A draw word scans one
// table entry per cycle over n = min(glyph_count, GLYPH_ENTRIES) entries, stopping at
// a hit, then passes fetch and step; each of the four vertex words is computed and
// then presented, held until m_tready. No new word is taken until the last vertex
// of the quad has been accepted.
// aresetn (synchronous) restores register defaults, pen, width and quad counter.
`include "glyph_quad_emitter_macros.svh"
module glyph_quad_emitter #(
    parameter int GLYPH_ENTRIES   = 256,
    parameter int QUADS_PER_BATCH = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // entry_index, codepoint, advance, plane_box, atlas_box, pen_x, pen_y
    input  logic [223:0] s_tdata,
    // operation
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // corner, vertex_x, vertex_y, tex_s, tex_t, vertex_color, quad_slot,
    // batch_full, line_width, padding
    output logic [175:0] m_tdata,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import gqe_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic [15:0] font_size_reg, spacing_reg;
    logic [31:0] color_reg, s_scale_reg, t_scale_reg;
    logic [8:0]  count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            font_size_reg <= 16'd4096;
            spacing_reg   <= '0;
            color_reg     <= 32'hFFFFFFFF;
            s_scale_reg   <= 32'h01000000;
            t_scale_reg   <= 32'h01000000;
            count_reg     <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FONT_SIZE:   font_size_reg <= cfg_data[15:0];
                REG_SPACING:     spacing_reg   <= cfg_data[15:0];
                REG_COLOR:       color_reg     <= cfg_data;
                REG_S_SCALE:     s_scale_reg   <= cfg_data;
                REG_T_SCALE:     t_scale_reg   <= cfg_data;
                REG_GLYPH_COUNT: count_reg     <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    gqe_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .op(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .status(status), .cmd(cmd)
    );

    logic [9:0] slot;
    logic [1:0] corner;
    logic [31:0] vx, vy, vc, lw;
    logic [15:0] ts, tt;
    logic bf;

    gqe_datapath #(.GLYPH_ENTRIES(GLYPH_ENTRIES), .QUADS_PER_BATCH(QUADS_PER_BATCH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .load_en(s_tvalid && s_tready && s_tuser == OP_LOAD),
        .entry_index(s_tdata[7:0]), .codepoint(s_tdata[15:8]),
        .advance(s_tdata[31:16]), .plane_box(s_tdata[95:32]),
        .atlas_box(s_tdata[159:96]), .pen_x(s_tdata[191:160]),
        .pen_y(s_tdata[223:192]),
        .font_size(font_size_reg), .glyph_spacing(spacing_reg),
        .text_color(color_reg), .tex_s_scale(s_scale_reg),
        .tex_t_scale(t_scale_reg), .glyph_count(count_reg),
        .corner(corner), .vertex_x(vx), .vertex_y(vy), .tex_s(ts), .tex_t(tt),
        .vertex_color(vc), .quad_slot(slot), .batch_full(bf), .line_width(lw),
        .last(m_tlast)
    );

    assign m_tdata = {3'd0, lw, bf, slot, vc, tt, ts, vy, vx, corner};

    `GQE_ASSERT_IMP(a_no_in_while_out, m_tvalid, !s_tready)
    `GQE_ASSERT_IMP(a_last_corner, m_tvalid && m_tlast, m_tdata[1:0] == CORNER_TL)
    `GQE_ASSERT_NEXT(a_hold_out, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule
